// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that fall away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define BKCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BKCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define BKCS_ASSERT(lbl, clk, rst_n, prop)
`define BKCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/bkcs_pkg.sv
// ----------------------------------------------------------------------------
// bkcs_pkg
// Shared types, codes and constants of the keyframe curve sampler.
// ----------------------------------------------------------------------------
package bkcs_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int MAX_ITER_DEF = 24;
    localparam int DATA_W       = 32;
    localparam int KEY_IDX_W    = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 31;
    localparam int KCNT_W       = 7;
    localparam int UOP_W        = 4;
    localparam int TOL_Q16      = 655;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 2'd2;

    localparam logic [UOP_W-1:0] UOP_FINAL = 4'd15;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef enum logic [UOP_W-1:0] {
        UOP_U2   = 4'd0,
        UOP_T2   = 4'd1,
        UOP_A    = 4'd2,
        UOP_D    = 4'd3,
        UOP_B    = 4'd4,
        UOP_C    = 4'd5,
        UOP_AX   = 4'd6,
        UOP_AY   = 4'd7,
        UOP_BX   = 4'd8,
        UOP_BY   = 4'd9,
        UOP_CX   = 4'd10,
        UOP_CY   = 4'd11,
        UOP_DX   = 4'd12,
        UOP_DY   = 4'd13,
        UOP_NONE = 4'd15
    } t_uop;

    typedef enum logic [1:0] {
        RES_HELD  = 2'd0,
        RES_KEY   = 2'd1,
        RES_CURVE = 2'd2
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_TIME  = 3'd1,
        S_SRD   = 3'd2,
        S_SCMP  = 3'd3,
        S_FETCH = 3'd4,
        S_LOAD  = 3'd5,
        S_EVAL  = 3'd6,
        S_DONE  = 3'd7
    } t_state;

    typedef struct packed {
        logic take;
        logic upd_time;
        logic init_eval;
        logic step_t;
        logic load_p3;
        logic load_seg;
        logic finish;
        t_res res_sel;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic ended;
        logic gt;
        logic close;
    } t_stat;

endpackage

// File: rtl/bkcs_ifs.sv
// ----------------------------------------------------------------------------
// bkcs item and result channels
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface bkcs_item_if;
    import bkcs_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [KEY_IDX_W-1:0]        key_index;
    logic signed [DATA_W-1:0]    key_time;
    logic signed [DATA_W-1:0]    key_value;
    logic signed [DATA_W-1:0]    in_handle_time;
    logic signed [DATA_W-1:0]    in_handle_value;
    logic signed [DATA_W-1:0]    out_handle_time;
    logic signed [DATA_W-1:0]    out_handle_value;
    logic signed [DATA_W-1:0]    time_step;

    modport source (output valid, operation, key_index, key_time, key_value,
                    in_handle_time, in_handle_value, out_handle_time,
                    out_handle_value, time_step, input ready);
    modport sink   (input valid, operation, key_index, key_time, key_value,
                    in_handle_time, in_handle_value, out_handle_time,
                    out_handle_value, time_step, output ready);
endinterface

interface bkcs_result_if;
    import bkcs_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [DATA_W-1:0]    sampled_value;
    logic                        looped;
    logic                        ended;

    modport source (output valid, sampled_value, looped, ended, input ready);
    modport sink   (input valid, sampled_value, looped, ended, output ready);
endinterface

// File: rtl/bkcs_ram.sv
// ----------------------------------------------------------------------------
// bkcs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bkcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bkcs_ctrl.sv
// ----------------------------------------------------------------------------
// bkcs_ctrl
// Sequencer: time update, key search, segment fetch, bisection rounds, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bkcs_ctrl #(
    parameter int MAX_KEYS = 64,
    parameter int MAX_ITER = 24,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int KW = $clog2(MAX_KEYS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [KW-1:0]    i_key_lim,
    input  bkcs_pkg::t_stat  i_stat,
    output bkcs_pkg::t_cmd   o_cmd,
    output logic             o_re,
    output logic [AW-1:0]    o_main_addr,
    output logic [AW-1:0]    o_l_addr,
    output logic [AW-1:0]    o_r_addr
);
    import bkcs_pkg::*;

    localparam int IW = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;
    localparam logic [IW-1:0] ITER_LAST = IW'(MAX_ITER - 1);

    t_state           r_state, n_state;
    logic [KW-1:0]    r_j, n_j;
    logic [UOP_W-1:0] r_uop, n_uop;
    logic [IW-1:0]    r_iter, n_iter;
    t_res             r_sel, n_sel;
    logic             r_ovalid, n_ovalid;
    logic [KW-1:0]    w_jm1;

    assign w_jm1 = r_j - KW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_j      <= '0;
            r_uop    <= '0;
            r_iter   <= '0;
            r_sel    <= RES_HELD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_uop    <= n_uop;
            r_iter   <= n_iter;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_uop       = r_uop;
        n_iter      = r_iter;
        n_sel       = r_sel;
        n_ovalid    = r_ovalid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.uop   = UOP_NONE;
        o_cmd.res_sel = r_sel;
        o_in_ready  = 1'b0;
        o_re        = 1'b0;
        o_main_addr = r_j[AW-1:0];
        o_l_addr    = w_jm1[AW-1:0];
        o_r_addr    = r_j[AW-1:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_op == OP_ADVANCE) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_TIME;
                end
            end
            S_TIME: begin
                o_cmd.upd_time = 1'b1;
                n_j            = '0;
                n_state        = S_SRD;
            end
            S_SRD: begin
                if (i_stat.ended) begin
                    n_sel   = RES_HELD;
                    n_state = S_DONE;
                end else begin
                    o_re    = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_stat.gt) begin
                    if (r_j == i_key_lim - KW'(1)) begin
                        n_sel   = RES_KEY;
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + KW'(1);
                        n_state = S_SRD;
                    end
                end else if (r_j == '0) begin
                    n_sel   = RES_KEY;
                    n_state = S_DONE;
                end else begin
                    o_cmd.load_p3 = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_re        = 1'b1;
                o_main_addr = w_jm1[AW-1:0];
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_seg  = 1'b1;
                o_cmd.init_eval = 1'b1;
                n_uop           = '0;
                n_iter          = '0;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (r_uop <= UOP_W'(UOP_DY)) begin
                    o_cmd.uop = t_uop'(r_uop);
                end
                if (r_uop == UOP_FINAL) begin
                    if (i_stat.close || r_iter == ITER_LAST) begin
                        n_sel   = RES_CURVE;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.step_t = 1'b1;
                        n_iter       = r_iter + IW'(1);
                        n_uop        = '0;
                    end
                end else begin
                    n_uop = r_uop + UOP_W'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ovalid     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

    `BKCS_ASSERT(a_finish_free, i_clk, i_rst_n, o_cmd.finish |-> (!r_ovalid || i_out_ready))
    `BKCS_ASSERT(a_iter_cap, i_clk, i_rst_n, (r_state == S_EVAL) |-> (r_iter <= ITER_LAST))
    `BKCS_ASSERT(a_round_restart, i_clk, i_rst_n, o_cmd.step_t |=> (r_state == S_EVAL && r_uop == '0))
endmodule

// File: rtl/bkcs_dp.sv
// ----------------------------------------------------------------------------
// bkcs_dp
// Datapath: keyframe RAMs, running time, shared multiplier, Bezier bisection.
// ----------------------------------------------------------------------------
module bkcs_dp #(
    parameter int MAX_KEYS = 64,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr_en,
    input  logic [bkcs_pkg::KEY_IDX_W-1:0]        i_key_index,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_key_time,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_key_value,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_in_handle_time,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_in_handle_value,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_out_handle_time,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_out_handle_value,
    input  logic signed [bkcs_pkg::DATA_W-1:0]    i_time_step,
    input  logic [bkcs_pkg::CFG_DATA_W-1:0]       i_duration,
    input  logic                                  i_loop_enable,
    input  bkcs_pkg::t_cmd                        i_cmd,
    input  logic                                  i_re,
    input  logic [AW-1:0]                         i_main_addr,
    input  logic [AW-1:0]                         i_l_addr,
    input  logic [AW-1:0]                         i_r_addr,
    output bkcs_pkg::t_stat                       o_stat,
    output logic signed [bkcs_pkg::DATA_W-1:0]    o_sampled_value,
    output logic                                  o_looped,
    output logic                                  o_ended
);
    import bkcs_pkg::*;

    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [63:0]          w_main_q, w_in_q, w_out_q;

    logic signed [31:0] r_run, r_held, r_dt;
    logic               r_looped, r_ended;
    logic signed [31:0] r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y, r_p3x, r_p3y;
    logic [31:0]        r_t, r_stp, r_u2, r_t2, r_wa, r_wb, r_wc, r_wd;
    logic signed [63:0] r_sx, r_sy;
    logic signed [65:0] r_prod;
    t_uop               r_wb_op;
    logic signed [31:0] r_res;
    logic               r_res_looped, r_res_ended;

    logic signed [33:0] w_sum, w_wrap, w_dur;
    logic               w_over;
    logic signed [31:0] w_now;
    logic [31:0]        w_u, w_ns;
    logic signed [32:0] w_opa, w_opb;
    logic [31:0]        w_q;
    logic [33:0]        w_q3;
    logic signed [33:0] w_x, w_y;
    logic signed [34:0] w_err;
    logic signed [31:0] w_ysat, w_keyt, w_res;

    assign w_we    = i_wr_en && (32'(i_key_index) < 32'(MAX_KEYS));
    assign w_waddr = AW'(i_key_index);

    bkcs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_main (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({i_key_value, i_key_time}),
        .i_re(i_re), .i_raddr(i_main_addr), .o_rdata(w_main_q)
    );
    bkcs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_inh (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({i_in_handle_value, i_in_handle_time}),
        .i_re(i_re), .i_raddr(i_r_addr), .o_rdata(w_in_q)
    );
    bkcs_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_outh (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({i_out_handle_value, i_out_handle_time}),
        .i_re(i_re), .i_raddr(i_l_addr), .o_rdata(w_out_q)
    );

    always_comb begin
        w_sum  = 34'(r_run) + 34'(r_dt);
        w_dur  = signed'({3'b000, i_duration});
        w_over = w_sum > w_dur;
        w_wrap = (w_over && i_loop_enable) ? (w_sum - w_dur) : w_sum;
        if (w_wrap > 34'(SMAX)) begin
            w_now = SMAX;
        end else if (w_wrap < 34'(SMIN)) begin
            w_now = SMIN;
        end else begin
            w_now = w_wrap[31:0];
        end
    end

    assign w_u  = 32'(33'h1_0000_0000 - {1'b0, r_t});
    assign w_ns = r_stp >> 1;

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_cmd.uop)
            UOP_U2: begin w_opa = {1'b0, w_u};  w_opb = {1'b0, w_u}; end
            UOP_T2: begin w_opa = {1'b0, r_t};  w_opb = {1'b0, r_t}; end
            UOP_A:  begin w_opa = {1'b0, r_u2}; w_opb = {1'b0, w_u}; end
            UOP_D:  begin w_opa = {1'b0, r_t2}; w_opb = {1'b0, r_t}; end
            UOP_B:  begin w_opa = {1'b0, r_u2}; w_opb = {1'b0, r_t}; end
            UOP_C:  begin w_opa = {1'b0, w_u};  w_opb = {1'b0, r_t2}; end
            UOP_AX: begin w_opa = {1'b0, r_wa}; w_opb = 33'(r_p0x); end
            UOP_AY: begin w_opa = {1'b0, r_wa}; w_opb = 33'(r_p0y); end
            UOP_BX: begin w_opa = {1'b0, r_wb}; w_opb = 33'(r_p1x); end
            UOP_BY: begin w_opa = {1'b0, r_wb}; w_opb = 33'(r_p1y); end
            UOP_CX: begin w_opa = {1'b0, r_wc}; w_opb = 33'(r_p2x); end
            UOP_CY: begin w_opa = {1'b0, r_wc}; w_opb = 33'(r_p2y); end
            UOP_DX: begin w_opa = {1'b0, r_wd}; w_opb = 33'(r_p3x); end
            UOP_DY: begin w_opa = {1'b0, r_wd}; w_opb = 33'(r_p3y); end
            default: begin w_opa = '0; w_opb = '0; end
        endcase
    end

    assign w_q  = r_prod[63:32];
    assign w_q3 = {1'b0, w_q, 1'b0} + {2'b00, w_q};

    assign w_x   = r_sx[63:30];
    assign w_y   = r_sy[63:30];
    assign w_err = 35'(w_x) - 35'(r_run);
    assign w_keyt = w_main_q[31:0];

    always_comb begin
        if (w_y > 34'(SMAX)) begin
            w_ysat = SMAX;
        end else if (w_y < 34'(SMIN)) begin
            w_ysat = SMIN;
        end else begin
            w_ysat = w_y[31:0];
        end
        case (i_cmd.res_sel)
            RES_KEY:   w_res = w_main_q[63:32];
            RES_CURVE: w_res = w_ysat;
            default:   w_res = r_held;
        endcase
    end

    assign o_stat.ended = r_ended;
    assign o_stat.gt    = r_run > w_keyt;
    assign o_stat.close = (w_err < 35'sd655) && (w_err > -35'sd655);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_held   <= '0;
            r_looped <= 1'b0;
            r_ended  <= 1'b0;
            r_wb_op  <= UOP_NONE;
        end else begin
            r_wb_op <= i_cmd.uop;
            if (i_cmd.upd_time) begin
                r_looped <= w_over && i_loop_enable;
                r_ended  <= w_over && !i_loop_enable;
                if (!(w_over && !i_loop_enable)) begin
                    r_run <= w_now;
                end
            end
            if (i_cmd.finish) begin
                r_held <= w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_dt <= i_time_step;
        end
        if (i_cmd.load_p3) begin
            r_p3x <= w_main_q[31:0];
            r_p3y <= w_main_q[63:32];
        end
        if (i_cmd.load_seg) begin
            r_p0x <= w_main_q[31:0];
            r_p0y <= w_main_q[63:32];
            r_p1x <= w_out_q[31:0];
            r_p1y <= w_out_q[63:32];
            r_p2x <= w_in_q[31:0];
            r_p2y <= w_in_q[63:32];
        end
        if (i_cmd.init_eval) begin
            r_t   <= 32'h8000_0000;
            r_stp <= 32'h8000_0000;
        end else if (i_cmd.step_t) begin
            r_stp <= w_ns;
            if (w_err > 35'sd0) begin
                r_t <= r_t - w_ns;
            end else begin
                r_t <= r_t + w_ns;
            end
        end
        r_prod <= w_opa * w_opb;
        case (r_wb_op)
            UOP_U2: r_u2 <= w_q;
            UOP_T2: r_t2 <= w_q;
            UOP_A:  r_wa <= {2'b00, r_prod[63:34]};
            UOP_D:  r_wd <= {2'b00, r_prod[63:34]};
            UOP_B:  r_wb <= w_q3[33:2];
            UOP_C:  r_wc <= w_q3[33:2];
            UOP_AX: r_sx <= r_prod[63:0];
            UOP_AY: r_sy <= r_prod[63:0];
            UOP_BX, UOP_CX, UOP_DX: r_sx <= r_sx + r_prod[63:0];
            UOP_BY, UOP_CY, UOP_DY: r_sy <= r_sy + r_prod[63:0];
            default: begin
            end
        endcase
        if (i_cmd.finish) begin
            r_res        <= w_res;
            r_res_looped <= r_looped;
            r_res_ended  <= r_ended;
        end
    end

    assign o_sampled_value = r_res;
    assign o_looped        = r_res_looped;
    assign o_ended         = r_res_ended;
endmodule

// File: rtl/bezier_keyframe_curve_sampler_core.sv
// ----------------------------------------------------------------------------
// bezier_keyframe_curve_sampler_core
// Keyframe store and cubic Bezier curve sampler, Q16.16 in and out.
// ----------------------------------------------------------------------------
// A write word stores one keyframe. An advance word scans keys in the search
// (one read of the keyframe RAM and one compare each, up to key_count) and,
// inside a segment, runs bisection rounds (1 to MAX_ITER), each round paced
// by the single shared 33x33 multiplier that forms the 14 products of one
// curve evaluation. An ended advance skips the search and returns the held
// value. A finished result sits in an output register while the next word
// is taken.
module bezier_keyframe_curve_sampler_core #(
    parameter int MAX_KEYS = bkcs_pkg::MAX_KEYS_DEF,
    parameter int MAX_ITER = bkcs_pkg::MAX_ITER_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bkcs_item_if.sink                       i_item,
    bkcs_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [bkcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bkcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bkcs_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KW = $clog2(MAX_KEYS + 1);

    logic [KCNT_W-1:0]     r_key_count;
    logic [CFG_DATA_W-1:0] r_duration;
    logic                  r_loop_enable;
    logic [KW-1:0]         w_key_lim;
    logic                  w_ready, w_acc;
    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic                  w_re;
    logic [AW-1:0]         w_main_addr, w_l_addr, w_r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count   <= KCNT_W'(1);
            r_duration    <= '0;
            r_loop_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_COUNT:   r_key_count   <= i_cfg_data[KCNT_W-1:0];
                CFG_DURATION:    r_duration    <= i_cfg_data;
                CFG_LOOP_ENABLE: r_loop_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_key_count == '0) begin
            w_key_lim = KW'(1);
        end else if (32'(r_key_count) > 32'(MAX_KEYS)) begin
            w_key_lim = KW'(MAX_KEYS);
        end else begin
            w_key_lim = KW'(r_key_count);
        end
    end

    assign i_item.ready = w_ready;
    assign w_acc        = i_item.valid && w_ready;

    bkcs_ctrl #(.MAX_KEYS(MAX_KEYS), .MAX_ITER(MAX_ITER)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.operation),
        .o_in_ready  (w_ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_key_lim   (w_key_lim),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_re        (w_re),
        .o_main_addr (w_main_addr),
        .o_l_addr    (w_l_addr),
        .o_r_addr    (w_r_addr)
    );

    bkcs_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_wr_en            (w_acc && i_item.operation == OP_WRITE),
        .i_key_index        (i_item.key_index),
        .i_key_time         (i_item.key_time),
        .i_key_value        (i_item.key_value),
        .i_in_handle_time   (i_item.in_handle_time),
        .i_in_handle_value  (i_item.in_handle_value),
        .i_out_handle_time  (i_item.out_handle_time),
        .i_out_handle_value (i_item.out_handle_value),
        .i_time_step        (i_item.time_step),
        .i_duration         (r_duration),
        .i_loop_enable      (r_loop_enable),
        .i_cmd              (w_cmd),
        .i_re               (w_re),
        .i_main_addr        (w_main_addr),
        .i_l_addr           (w_l_addr),
        .i_r_addr           (w_r_addr),
        .o_stat             (w_stat),
        .o_sampled_value    (o_result.sampled_value),
        .o_looped           (o_result.looped),
        .o_ended            (o_result.ended)
    );
endmodule
